/* hw/rtl/dvgcj_pkg.sv */
// ============================================================================
// dvgcj_pkg
// Types, widths and helpers shared by the decay vertex geometric
// constraint jacobian pipeline.
// ============================================================================
package dvgcj_pkg;

    localparam int NUM_AXES    = 3;
    localparam int MAG_W       = 32;                 // |p| in Q16.16, unsigned
    localparam int QFRAC       = 16;
    localparam int DERIV_SHIFT = 15;

    // pipelined divider shapes
    localparam int QDIV_DVD_W = MAG_W + QFRAC;       // |p_j| << 16
    localparam int QDIV_QUO_W = QFRAC + 1;           // |q_j| <= 2^16
    localparam int RDIV_DVD_W = 2 * MAG_W - 1;       // |tau * p_i| <= 2^62
    localparam int DDIV_DVD_W = 2 * MAG_W - DERIV_SHIFT + 1; // |tau * w| >> 15
    localparam int DIV_QUO_W  = 32;

    localparam int SQRT_LAT = MAG_W;
    localparam int QDIV_LAT = QDIV_QUO_W + 1;
    localparam int DIV_LAT  = DIV_QUO_W + 1;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic signed [31:0] mother_x;
        logic signed [31:0] mother_y;
        logic signed [31:0] mother_z;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] decay_length;
    } t_item;

    typedef struct packed {
        t_axis              axis;
        logic signed [31:0] residual;
        logic signed [31:0] deriv_px;
        logic signed [31:0] deriv_py;
        logic signed [31:0] deriv_pz;
        logic signed [31:0] deriv_tau;
        logic               zero_momentum;
        logic               last;
    } t_row;

    // per-row context that travels beside the arithmetic
    typedef struct packed {
        logic signed [32:0]           diff;     // mother - vertex on this axis
        logic signed [31:0]           tau;
        logic [RDIV_DVD_W-1:0]        tp_abs;   // |tau * p_axis|
        logic                         tp_neg;
        logic [NUM_AXES-1:0][MAG_W-1:0] p_abs;
        logic [NUM_AXES-1:0]          p_neg;
        logic [MAG_W-1:0]             mag;
        logic signed [QDIV_QUO_W:0]   qa;       // q of this axis
        logic [NUM_AXES-1:0]          d_neg;    // sign of tau * w per column
        logic                         zero;
        t_axis                        axis;
        logic                         last;
    } t_side;

    // signed, saturated value of a magnitude quotient
    function automatic logic signed [31:0] f_sat_quo(
        input logic [DIV_QUO_W-1:0] quo,
        input logic                 ovf,
        input logic                 neg
    );
        logic signed [DIV_QUO_W:0] v;
        v = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        priority if (ovf) begin
            f_sat_quo = neg ? SAT_MIN : SAT_MAX;
        end else if (v > 33'sd2147483647) begin
            f_sat_quo = SAT_MAX;
        end else if (v < -33'sd2147483648) begin
            f_sat_quo = SAT_MIN;
        end else begin
            f_sat_quo = 32'(v);
        end
    endfunction

endpackage

/* hw/rtl/dvgcj_if.sv */
// ============================================================================
// dvgcj stream interfaces
// Valid/ready channels for input items and result rows.
// ============================================================================
interface dvgcj_item_if;
    logic                 valid;
    logic                 ready;
    dvgcj_pkg::t_item     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dvgcj_row_if;
    logic                 valid;
    logic                 ready;
    dvgcj_pkg::t_row      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dvgcj_sqrt.sv */
// ============================================================================
// dvgcj_sqrt
// Pipelined integer square root, one result bit per register stage.
// ============================================================================
module dvgcj_sqrt (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [2*dvgcj_pkg::MAG_W-1:0]       i_s,
    output logic [dvgcj_pkg::MAG_W-1:0]         o_root
);

    localparam int RW     = dvgcj_pkg::MAG_W;
    localparam int SW     = 2 * RW;
    localparam int REM_W  = RW + 2;
    localparam int STAGES = RW;

    logic [REM_W-1:0] r_rem  [STAGES];
    logic [RW-1:0]    r_root [STAGES];
    logic [SW-1:0]    r_s    [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [REM_W-1:0] w_rem_in;
        logic [RW-1:0]    w_root_in;
        logic [SW-1:0]    w_s_in;
        logic [REM_W+1:0] w_t;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_s_in    = i_s;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_s_in    = r_s[k-1];
        end

        assign w_t     = {w_rem_in, w_s_in[SW-1 -: 2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_ge    = w_t >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {w_root_in[RW-2:0], w_ge};
            end
        end

        if (k < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? REM_W'(w_t - w_trial) : REM_W'(w_t);
                    r_s[k]   <= {w_s_in[SW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[STAGES-1];

endmodule

/* hw/rtl/dvgcj_div.sv */
// ============================================================================
// dvgcj_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// an up-front check for quotients that do not fit.
// ============================================================================
module dvgcj_div #(
    parameter int DIVD_W = 48,
    parameter int QUO_W  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [DIVD_W-1:0]            i_dividend,
    input  logic [dvgcj_pkg::MAG_W-1:0]  i_divisor,
    output logic [QUO_W-1:0]             o_quo,
    output logic                         o_ovf
);

    localparam int RW = dvgcj_pkg::MAG_W;

    logic [RW-1:0]    r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_x   [QUO_W+1];  // dividend bits shift out, quotient bits in
    logic [RW-1:0]    r_d   [QUO_W];
    logic             r_ovf [QUO_W+1];
    logic [DIVD_W-1:0] w_hi;

    assign w_hi = i_dividend >> QUO_W;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(w_hi);
            r_x[0]   <= i_dividend[QUO_W-1:0];
            r_d[0]   <= i_divisor;
            r_ovf[0] <= w_hi >= DIVD_W'(i_divisor);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [RW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_rem[k-1], r_x[k-1][QUO_W-1]};
        assign w_ge = w_t >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? RW'(w_t - {1'b0, r_d[k-1]}) : RW'(w_t);
                r_x[k]   <= {r_x[k-1][QUO_W-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QUO_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= r_d[k-1];
                end
            end
        end
    end

    assign o_quo = r_x[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

/* hw/rtl/decay_vertex_geo_constraint_jacobian.sv */
// ============================================================================
// decay_vertex_geo_constraint_jacobian
// Geometric vertex constraint of a decay tree fit: per axis residual and
// its derivatives by momentum and decay length, signed Q16.16, saturated.
// ============================================================================
//  channel   dir   handshake        payload
//  i_item    in    valid / ready    mother, vertex, momentum, decay length
//  o_row     out   valid / ready    axis, residual, derivatives, flags
//
//  each item gives three rows, one per cycle while o_row does not stall;
//  the row sequencer at the pipeline head takes the next item as z leaves
//  a row passes stages a to c, the square root, the q division, stages 5
//  to 8, the final divisions and the output register; the pipeline moves as
//  one; a stalled o_row freezes every stage and no row is lost
//  reset clears only valid bits and the row sequencer
// ============================================================================
module decay_vertex_geo_constraint_jacobian (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvgcj_item_if.sink   i_item,
    dvgcj_row_if.source  o_row
);

    localparam int NA   = dvgcj_pkg::NUM_AXES;
    localparam int MW   = dvgcj_pkg::MAG_W;
    localparam int QW   = dvgcj_pkg::QDIV_QUO_W;
    localparam int DQW  = dvgcj_pkg::DIV_QUO_W;
    localparam int SLAT = dvgcj_pkg::SQRT_LAT;
    localparam int QLAT = dvgcj_pkg::QDIV_LAT;
    localparam int DLAT = dvgcj_pkg::DIV_LAT;
    localparam logic signed [34:0] W_ONE = 35'sh1_0000_0000;

    logic w_en;
    logic w_take;
    dvgcj_pkg::t_row r_o;
    logic            r_o_vld;

    // ------------------------------------------------------------------
    // row sequencer
    // ------------------------------------------------------------------
    dvgcj_pkg::t_item r_item;
    logic             r_item_vld;
    dvgcj_pkg::t_axis r_row;
    dvgcj_pkg::t_axis n_row;

    assign w_en         = !r_o_vld || o_row.ready;
    assign i_item.ready = !r_item_vld || (w_en && r_row == dvgcj_pkg::AXIS_Z);
    assign w_take       = i_item.valid && i_item.ready;

    always_comb begin
        unique case (r_row)
            dvgcj_pkg::AXIS_X: n_row = dvgcj_pkg::AXIS_Y;
            dvgcj_pkg::AXIS_Y: n_row = dvgcj_pkg::AXIS_Z;
            default:           n_row = dvgcj_pkg::AXIS_X;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_row      <= dvgcj_pkg::AXIS_X;
        end else if (w_take) begin
            r_item_vld <= 1'b1;
            r_row      <= dvgcj_pkg::AXIS_X;
        end else if (w_en && r_item_vld) begin
            if (r_row == dvgcj_pkg::AXIS_Z) begin
                r_item_vld <= 1'b0;
            end
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item.data;
        end
    end

    // ------------------------------------------------------------------
    // stage a: pick the row, differences and magnitudes
    // ------------------------------------------------------------------
    logic signed [31:0] w_m, w_v, w_pa;
    logic signed [31:0] w_p [NA];

    assign w_p[0] = r_item.mom_x;
    assign w_p[1] = r_item.mom_y;
    assign w_p[2] = r_item.mom_z;

    always_comb begin
        unique case (r_row)
            dvgcj_pkg::AXIS_Y: begin
                w_m = r_item.mother_y; w_v = r_item.vertex_y; w_pa = r_item.mom_y;
            end
            dvgcj_pkg::AXIS_Z: begin
                w_m = r_item.mother_z; w_v = r_item.vertex_z; w_pa = r_item.mom_z;
            end
            default: begin
                w_m = r_item.mother_x; w_v = r_item.vertex_x; w_pa = r_item.mom_x;
            end
        endcase
    end

    logic                     r_a_vld;
    logic signed [32:0]       r_a_diff;
    logic signed [31:0]       r_a_tau;
    logic signed [31:0]       r_a_pa;
    logic [NA-1:0][MW-1:0]    r_a_pabs;
    logic [NA-1:0]            r_a_pneg;
    dvgcj_pkg::t_axis         r_a_axis;
    logic                     r_a_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_diff <= $signed({w_m[31], w_m}) - $signed({w_v[31], w_v});
            r_a_tau  <= r_item.decay_length;
            r_a_pa   <= w_pa;
            r_a_axis <= r_row;
            r_a_last <= (r_row == dvgcj_pkg::AXIS_Z);
            for (int j = 0; j < NA; j++) begin
                r_a_pneg[j] <= w_p[j][31];
                r_a_pabs[j] <= w_p[j][31] ? MW'(32'd0 - w_p[j]) : MW'(w_p[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage b: squares and tau * p on this axis
    // ------------------------------------------------------------------
    logic                     r_b_vld;
    logic [2*MW-1:0]          r_b_sq [NA];
    logic signed [63:0]       r_b_tp;
    logic signed [32:0]       r_b_diff;
    logic signed [31:0]       r_b_tau;
    logic [NA-1:0][MW-1:0]    r_b_pabs;
    logic [NA-1:0]            r_b_pneg;
    dvgcj_pkg::t_axis         r_b_axis;
    logic                     r_b_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NA; j++) begin
                r_b_sq[j] <= (2*MW)'(r_a_pabs[j]) * (2*MW)'(r_a_pabs[j]);
            end
            r_b_tp   <= 64'(r_a_tau) * 64'(r_a_pa);
            r_b_diff <= r_a_diff;
            r_b_tau  <= r_a_tau;
            r_b_pabs <= r_a_pabs;
            r_b_pneg <= r_a_pneg;
            r_b_axis <= r_a_axis;
            r_b_last <= r_a_last;
        end
    end

    // ------------------------------------------------------------------
    // stage c: |p|^2 and the row context
    // ------------------------------------------------------------------
    logic                r_c_vld;
    logic [2*MW-1:0]     r_c_s;
    dvgcj_pkg::t_side    w_c_side;
    dvgcj_pkg::t_side    r_c_side;

    always_comb begin
        w_c_side        = '0;
        w_c_side.diff   = r_b_diff;
        w_c_side.tau    = r_b_tau;
        w_c_side.tp_neg = r_b_tp[63];
        w_c_side.tp_abs = r_b_tp[63] ? dvgcj_pkg::RDIV_DVD_W'(-r_b_tp)
                                     : dvgcj_pkg::RDIV_DVD_W'(r_b_tp);
        w_c_side.p_abs  = r_b_pabs;
        w_c_side.p_neg  = r_b_pneg;
        w_c_side.zero   = (r_b_pabs == '0);
        w_c_side.axis   = r_b_axis;
        w_c_side.last   = r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_s    <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_side <= w_c_side;
        end
    end

    // ------------------------------------------------------------------
    // |p| by pipelined square root
    // ------------------------------------------------------------------
    logic [MW-1:0]    w_root;
    dvgcj_pkg::t_side r_d_side [SLAT];
    logic             r_d_vld  [SLAT];

    dvgcj_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s    (r_c_s),
        .o_root (w_root)
    );

    // ------------------------------------------------------------------
    // q_j = p_j * 2^16 / |p| for all three columns
    // ------------------------------------------------------------------
    dvgcj_pkg::t_side w_e_in;
    logic [QW-1:0]    w_qquo [NA];
    dvgcj_pkg::t_side r_e_side [QLAT];
    logic             r_e_vld  [QLAT];

    always_comb begin
        w_e_in     = r_d_side[SLAT-1];
        w_e_in.mag = w_root;
    end

    for (genvar j = 0; j < NA; j++) begin : g_qdiv
        dvgcj_div #(
            .DIVD_W (dvgcj_pkg::QDIV_DVD_W),
            .QUO_W  (QW)
        ) u_qdiv (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_dividend ({w_e_in.p_abs[j], dvgcj_pkg::QFRAC'(0)}),
            .i_divisor  (w_root),
            .o_quo      (w_qquo[j]),
            .o_ovf      ()
        );
    end

    // ------------------------------------------------------------------
    // stage 5: signed q, stage 6: q_i*q_j, stage 7: w, stage 8: tau*w
    // ------------------------------------------------------------------
    dvgcj_pkg::t_side      w_e_end;
    dvgcj_pkg::t_side      w_5_side;
    logic signed [QW:0]    w_q [NA];
    logic signed [QW:0]    w_qa;

    assign w_e_end = r_e_side[QLAT-1];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            if (w_e_end.zero) begin
                w_q[j] = '0;
            end else if (w_e_end.p_neg[j]) begin
                w_q[j] = -$signed({1'b0, w_qquo[j]});
            end else begin
                w_q[j] = $signed({1'b0, w_qquo[j]});
            end
        end
        unique case (w_e_end.axis)
            dvgcj_pkg::AXIS_Y: w_qa = w_q[1];
            dvgcj_pkg::AXIS_Z: w_qa = w_q[2];
            default:           w_qa = w_q[0];
        endcase
        w_5_side    = w_e_end;
        w_5_side.qa = w_qa;
    end

    logic                   r5_vld, r6_vld, r7_vld, r8_vld;
    dvgcj_pkg::t_side       r5_side, r6_side, r7_side, r8_side;
    logic signed [QW:0]     r5_q  [NA];
    logic signed [2*QW+1:0] r6_qq [NA];
    logic signed [32:0]     r7_w  [NA];
    logic signed [64:0]     r8_tw [NA];
    logic signed [34:0]     w_wf  [NA];
    logic signed [34:0]     w_wh  [NA];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            w_wf[j] = ((r6_side.axis == dvgcj_pkg::t_axis'(j)) ? W_ONE : 35'sd0)
                      - 35'(r6_qq[j]);
            // halve toward zero
            w_wh[j] = w_wf[j] + ((w_wf[j][34] & w_wf[j][0]) ? 35'sd1 : 35'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side    <= w_5_side;
            r6_side    <= r5_side;
            r7_side    <= r6_side;
            r8_side    <= r7_side;
            for (int j = 0; j < NA; j++) begin
                r5_q[j]  <= w_q[j];
                r6_qq[j] <= (2*QW+2)'(r5_side.qa) * (2*QW+2)'(r5_q[j]);
                r7_w[j]  <= 33'(w_wh[j] >>> 1);
                r8_tw[j] <= 65'(r7_side.tau) * 65'(r7_w[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // final divisions: tau*w / (|p| * 2^15) per column, tau*p / |p|
    // ------------------------------------------------------------------
    dvgcj_pkg::t_side  w_f_in;
    logic [64:0]       w_tw_abs [NA];
    logic [DQW-1:0]    w_dquo   [NA];
    logic              w_dovf   [NA];
    logic [DQW-1:0]    w_rquo;
    logic              w_rovf;
    dvgcj_pkg::t_side  r_f_side [DLAT];
    logic              r_f_vld  [DLAT];

    always_comb begin
        w_f_in = r8_side;
        for (int j = 0; j < NA; j++) begin
            w_f_in.d_neg[j] = r8_tw[j][64];
            w_tw_abs[j]     = r8_tw[j][64] ? 65'(-r8_tw[j]) : 65'(r8_tw[j]);
        end
    end

    for (genvar j = 0; j < NA; j++) begin : g_ddiv
        dvgcj_div #(
            .DIVD_W (dvgcj_pkg::DDIV_DVD_W),
            .QUO_W  (DQW)
        ) u_ddiv (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_dividend (w_tw_abs[j][dvgcj_pkg::DERIV_SHIFT +: dvgcj_pkg::DDIV_DVD_W]),
            .i_divisor  (r8_side.mag),
            .o_quo      (w_dquo[j]),
            .o_ovf      (w_dovf[j])
        );
    end

    dvgcj_div #(
        .DIVD_W (dvgcj_pkg::RDIV_DVD_W),
        .QUO_W  (DQW)
    ) u_rdiv (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r8_side.tp_abs),
        .i_divisor  (r8_side.mag),
        .o_quo      (w_rquo),
        .o_ovf      (w_rovf)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    dvgcj_pkg::t_side    w_f_end;
    dvgcj_pkg::t_row     w_row;
    logic signed [33:0]  w_rterm;
    logic signed [33:0]  w_rsum;
    logic signed [31:0]  w_deriv [NA];

    assign w_f_end = r_f_side[DLAT-1];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            w_deriv[j] = w_f_end.zero ? 32'sd0
                       : dvgcj_pkg::f_sat_quo(w_dquo[j], w_dovf[j], w_f_end.d_neg[j]);
        end
        if (w_f_end.zero) begin
            w_rterm = '0;
        end else if (w_rovf) begin
            // cannot happen for |tau*p| / |p|, clamp anyway
            w_rterm = w_f_end.tp_neg ? -34'sh8000_0000 : 34'sh8000_0000;
        end else if (w_f_end.tp_neg) begin
            w_rterm = -$signed({2'b00, w_rquo});
        end else begin
            w_rterm = $signed({2'b00, w_rquo});
        end
        w_rsum = 34'($signed(w_f_end.diff)) + w_rterm;

        w_row.axis          = w_f_end.axis;
        priority if (w_rsum > 34'sd2147483647) begin
            w_row.residual = dvgcj_pkg::SAT_MAX;
        end else if (w_rsum < -34'sd2147483648) begin
            w_row.residual = dvgcj_pkg::SAT_MIN;
        end else begin
            w_row.residual = 32'(w_rsum);
        end
        w_row.deriv_px      = w_deriv[0];
        w_row.deriv_py      = w_deriv[1];
        w_row.deriv_pz      = w_deriv[2];
        w_row.deriv_tau     = 32'($signed(w_f_end.qa));
        w_row.zero_momentum = w_f_end.zero;
        w_row.last          = w_f_end.last;
    end

    // ------------------------------------------------------------------
    // valid bits and delay lines
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k < SLAT; k++) r_d_vld[k] <= 1'b0;
            for (int k = 0; k < QLAT; k++) r_e_vld[k] <= 1'b0;
            for (int k = 0; k < DLAT; k++) r_f_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_a_vld    <= r_item_vld;
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_d_vld[0] <= r_c_vld;
            for (int k = 1; k < SLAT; k++) r_d_vld[k] <= r_d_vld[k-1];
            r_e_vld[0] <= r_d_vld[SLAT-1];
            for (int k = 1; k < QLAT; k++) r_e_vld[k] <= r_e_vld[k-1];
            r5_vld     <= r_e_vld[QLAT-1];
            r6_vld     <= r5_vld;
            r7_vld     <= r6_vld;
            r8_vld     <= r7_vld;
            r_f_vld[0] <= r8_vld;
            for (int k = 1; k < DLAT; k++) r_f_vld[k] <= r_f_vld[k-1];
            r_o_vld    <= r_f_vld[DLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_side[0] <= r_c_side;
            for (int k = 1; k < SLAT; k++) r_d_side[k] <= r_d_side[k-1];
            r_e_side[0] <= w_e_in;
            for (int k = 1; k < QLAT; k++) r_e_side[k] <= r_e_side[k-1];
            r_f_side[0] <= w_f_in;
            for (int k = 1; k < DLAT; k++) r_f_side[k] <= r_f_side[k-1];
            r_o <= w_row;
        end
    end

    assign o_row.valid = r_o_vld;
    assign o_row.data  = r_o;

`ifndef SYNTHESIS
    a_last_on_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid && o_row.data.last |-> o_row.data.axis == dvgcj_pkg::AXIS_Z)
        else $error("last flag on a row other than z");

    a_zero_derivs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid && o_row.data.zero_momentum |->
            o_row.data.deriv_tau == 32'sd0 && o_row.data.deriv_px == 32'sd0 &&
            o_row.data.deriv_py == 32'sd0 && o_row.data.deriv_pz == 32'sd0)
        else $error("nonzero derivative with zero momentum");

    a_tau_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid |-> $signed(o_row.data.deriv_tau) <= 32'sd65536 &&
                        $signed(o_row.data.deriv_tau) >= -32'sd65536)
        else $error("direction cosine out of range");

    a_take_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_vld && i_item.ready |-> r_row == dvgcj_pkg::AXIS_Z && w_en)
        else $error("new transaction taken before the z row left");
`endif

endmodule

/* tb/sv/decay_vertex_geo_constraint_jacobian_tb.sv */
// ============================================================================
// decay_vertex_geo_constraint_jacobian_tb
// Drives input items with random gaps, predicts the three constraint rows of
// each accepted transaction and checks every row field by field in order.
// ============================================================================
module decay_vertex_geo_constraint_jacobian_tb;

    localparam int LATENCY   = 92;
    localparam int N_RANDOM  = 330;
    localparam longint LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;

    dvgcj_item_if item_ch ();
    dvgcj_row_if  row_ch ();

    decay_vertex_geo_constraint_jacobian dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_row   (row_ch.source)
    );

    dvgcj_pkg::t_row rows_due[$];
    int     n_err;
    longint cycle;
    bit     drive_done;
    int     hold_off;       // cycles of forced output stall
    bit     sink_quiet;

    typedef struct {
        dvgcj_pkg::t_item it;
        bit               has_exp;
        dvgcj_pkg::t_row  e0;
    } t_vec;

    t_vec dir_vecs[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return dvgcj_pkg::SAT_MAX;
        if (x < -64'sd2147483648) return dvgcj_pkg::SAT_MIN;
        return 32'(x);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_rows(input dvgcj_pkg::t_item it);
        longint mo[3], vt[3], pm[3], q[3];
        longint tau, mag, res, w, d, a;
        longint unsigned s;
        bit zero;
        dvgcj_pkg::t_row r;
        mo[0] = it.mother_x; mo[1] = it.mother_y; mo[2] = it.mother_z;
        vt[0] = it.vertex_x; vt[1] = it.vertex_y; vt[2] = it.vertex_z;
        pm[0] = it.mom_x;    pm[1] = it.mom_y;    pm[2] = it.mom_z;
        tau = it.decay_length;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            a = pm[i] < 0 ? -pm[i] : pm[i];
            s += longint'(a) * longint'(a);
        end
        zero = (s == 0);
        mag = int_sqrt(s);
        for (int i = 0; i < 3; i++) q[i] = zero ? 0 : (pm[i] * 65536) / mag;
        for (int i = 0; i < 3; i++) begin
            res = mo[i] - vt[i];
            if (!zero) res += (tau * pm[i]) / mag;
            r.axis = dvgcj_pkg::t_axis'(i);
            r.residual = clamp32(res);
            for (int j = 0; j < 3; j++) begin
                d = 0;
                if (!zero) begin
                    w = ((i == j) ? 64'sd4294967296 : 0) - q[i] * q[j];
                    w = w / 2;
                    d = (tau * w) / (mag * 32768);
                end
                case (j)
                    0: r.deriv_px = clamp32(d);
                    1: r.deriv_py = clamp32(d);
                    default: r.deriv_pz = clamp32(d);
                endcase
            end
            r.deriv_tau = 32'(q[i]);
            r.zero_momentum = zero;
            r.last = (i == 2);
            rows_due = {rows_due, r};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_err++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            3: return 32'(int'($urandom_range(0, 8388608)) - 4194304);
            default: return $urandom;
        endcase
    endfunction

    function automatic dvgcj_pkg::t_item rand_item();
        dvgcj_pkg::t_item it;
        it.mother_x = rand_field(); it.mother_y = rand_field();
        it.mother_z = rand_field(); it.vertex_x = rand_field();
        it.vertex_y = rand_field(); it.vertex_z = rand_field();
        it.mom_x = rand_field(); it.mom_y = rand_field(); it.mom_z = rand_field();
        it.decay_length = rand_field();
        if ($urandom_range(0, 19) == 0) begin
            it.mom_x = 0; it.mom_y = 0; it.mom_z = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            // tiny momentum drives the derivatives into saturation
            it.mom_x = $urandom_range(0, 3); it.mom_y = 0; it.mom_z = 1;
        end
        return it;
    endfunction

    function automatic dvgcj_pkg::t_item mk(input logic [31:0] m, v, px, py, pz, tau);
        dvgcj_pkg::t_item it;
        it.mother_x = m;  it.mother_y = m;  it.mother_z = m;
        it.vertex_x = v;  it.vertex_y = v;  it.vertex_z = v;
        it.mom_x = px; it.mom_y = py; it.mom_z = pz; it.decay_length = tau;
        return it;
    endfunction

    task automatic add_vec(input dvgcj_pkg::t_item it, input bit has,
                           input dvgcj_pkg::t_row e);
        t_vec tv;
        tv.it = it; tv.has_exp = has; tv.e0 = e;
        dir_vecs = {dir_vecs, tv};
    endtask

    task automatic send_item(input dvgcj_pkg::t_item it);
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        predict_rows(it);
        @(negedge i_clk);
    endtask

    task automatic src_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        dvgcj_pkg::t_row e;
        dvgcj_pkg::t_item it;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        drive_done = 0;
        n_err = 0;
        hold_off = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero momentum: residual is m - v, derivatives zero
        e = '{dvgcj_pkg::AXIS_X, 32'sd5, 0, 0, 0, 0, 1'b1, 1'b0};
        add_vec(mk(32'd7, 32'd2, 0, 0, 0, 32'h0001_0000), 1, e);
        // unit momentum along x, zero tau
        e = '{dvgcj_pkg::AXIS_X, 0, 0, 0, 0, 32'h0001_0000, 1'b0, 1'b0};
        add_vec(mk(0, 0, 32'h0001_0000, 0, 0, 0), 1, e);
        // residual saturation both ways
        e = '{dvgcj_pkg::AXIS_X, dvgcj_pkg::SAT_MAX, 0, 0, 0, 0, 1'b1, 1'b0};
        add_vec(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0), 1, e);
        e = '{dvgcj_pkg::AXIS_X, dvgcj_pkg::SAT_MIN, 0, 0, 0, 0, 1'b1, 1'b0};
        add_vec(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0), 1, e);
        // extremes checked against the predictor
        add_vec(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000), 0, e);
        add_vec(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, e);
        add_vec(mk(0, 0, 1, 0, 0, 32'h7FFF_FFFF), 0, e);
        add_vec(mk(0, 0, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000), 0, e);
        add_vec(mk(32'h1234_5678, 32'h0FED_CBA9, 32'h0001_0000, 32'h0002_0000,
                   32'hFFFE_0000, 32'h0003_0000), 0, e);
        add_vec(mk(0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF), 0, e);
        add_vec(mk(0, 0, 1, 1, 1, 32'h8000_0000), 0, e);

        foreach (dir_vecs[k]) begin
            if (dir_vecs[k].has_exp) begin
                // compare the typed row to the predicted x row
                predict_rows(dir_vecs[k].it);
                if (rows_due[$-2] != dir_vecs[k].e0)
                    report_mismatch("directed x row", rows_due[$-2].residual,
                                    dir_vecs[k].e0.residual);
                void'(rows_due.pop_back()); void'(rows_due.pop_back());
                void'(rows_due.pop_back());
            end
            send_item(dir_vecs[k].it);
            src_gap();
        end

        // long output stall while items keep coming
        hold_off = 400;
        for (int n = 0; n < 60; n++) send_item(rand_item());
        item_ch.valid <= 1'b0;
        // pause until every row has drained
        while (rows_due.size() != 0) @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) sink_quiet = 1;
            if (n == 250) sink_quiet = 0;
            send_item(rand_item());
            src_gap();
        end
        item_ch.valid <= 1'b0;
        drive_done = 1;
    end

    // sink side
    initial begin
        int g;
        row_ch.ready = 1'b0;
        sink_quiet = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                row_ch.ready <= 1'b0;
            end else if (sink_quiet) begin
                row_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(1, 3);
                row_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                row_ch.ready <= 1'b1;
            end
        end
    end

    // row checker
    always @(posedge i_clk) begin
        dvgcj_pkg::t_row got, want;
        if (i_rst_n && row_ch.valid && row_ch.ready) begin
            got = row_ch.data;
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected row", got.residual, 0);
            end else begin
                want = rows_due.pop_front();
                if (got.axis != want.axis)
                    report_mismatch("axis", 32'(got.axis), 32'(want.axis));
                if (got.residual != want.residual)
                    report_mismatch("residual", got.residual, want.residual);
                if (got.deriv_px != want.deriv_px)
                    report_mismatch("deriv_px", got.deriv_px, want.deriv_px);
                if (got.deriv_py != want.deriv_py)
                    report_mismatch("deriv_py", got.deriv_py, want.deriv_py);
                if (got.deriv_pz != want.deriv_pz)
                    report_mismatch("deriv_pz", got.deriv_pz, want.deriv_pz);
                if (got.deriv_tau != want.deriv_tau)
                    report_mismatch("deriv_tau", got.deriv_tau, want.deriv_tau);
                if (got.zero_momentum != want.zero_momentum)
                    report_mismatch("zero_momentum", 32'(got.zero_momentum),
                                    32'(want.zero_momentum));
                if (got.last != want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle > LIMIT) begin
                $display("decay_vertex_geo_constraint_jacobian_tb: FAIL");
                $finish;
            end
            if (drive_done && rows_due.size() == 0) begin
                repeat (2 * LATENCY) @(posedge i_clk);
                if (n_err == 0 && rows_due.size() == 0) begin
                    $display("decay_vertex_geo_constraint_jacobian_tb: PASS");
                end else begin
                    $display("decay_vertex_geo_constraint_jacobian_tb: FAIL");
                end
                $finish;
            end
        end
    end

endmodule
